FILE: hw/rtl/cdft_pkg.sv
// ----------------------------------------------------------------------------
// cdft_pkg
// Shared types, constants and the twiddle table of the direct complex DFT.
// ----------------------------------------------------------------------------
package cdft_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TABLE_BITS      = 6;
    localparam int TWID_BITS       = 16;
    localparam int FRAC_BITS       = 15;
    localparam int BIN_BITS        = 23;
    localparam int IDX_BITS        = 6;
    localparam int LOG2_BITS       = 3;
    localparam int CFG_AW          = 3;
    localparam int CFG_DW          = 32;
    localparam int SIN_OFFSET      = 48;

    localparam logic [LOG2_BITS-1:0] LOG2_MIN   = 3'd2;
    localparam logic [LOG2_BITS-1:0] LOG2_RESET = 3'd6;

    // register index taken from paddr[2]
    localparam logic CFG_IDX_INV  = 1'b0;
    localparam logic CFG_IDX_LOG2 = 1'b1;

    localparam logic signed [TWID_BITS-1:0] COS_TAB [0:(1<<TABLE_BITS)-1] = '{
         16'sd32767,  16'sd32610,  16'sd32138,  16'sd31357,
         16'sd30274,  16'sd28899,  16'sd27246,  16'sd25330,
         16'sd23170,  16'sd20788,  16'sd18205,  16'sd15447,
         16'sd12540,   16'sd9512,   16'sd6393,   16'sd3212,
             16'sd0,  -16'sd3212,  -16'sd6393,  -16'sd9512,
        -16'sd12540, -16'sd15447, -16'sd18205, -16'sd20788,
        -16'sd23170, -16'sd25330, -16'sd27246, -16'sd28899,
        -16'sd30274, -16'sd31357, -16'sd32138, -16'sd32610,
        -16'sd32768, -16'sd32610, -16'sd32138, -16'sd31357,
        -16'sd30274, -16'sd28899, -16'sd27246, -16'sd25330,
        -16'sd23170, -16'sd20788, -16'sd18205, -16'sd15447,
        -16'sd12540,  -16'sd9512,  -16'sd6393,  -16'sd3212,
             16'sd0,   16'sd3212,   16'sd6393,   16'sd9512,
         16'sd12540,  16'sd15447,  16'sd18205,  16'sd20788,
         16'sd23170,  16'sd25330,  16'sd27246,  16'sd28899,
         16'sd30274,  16'sd31357,  16'sd32138,  16'sd32610
    };

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CALC,
        SEQ_FLUSH
    } t_seq_state;

    typedef struct packed {
        logic                 inv;
        logic [LOG2_BITS-1:0] l_eff;
        logic                 len_wr;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic                last_k;
        logic [IDX_BITS-1:0] k;
    } t_mac_ctrl;

endpackage

FILE: hw/rtl/cdft_ram.sv
// ----------------------------------------------------------------------------
// cdft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/cdft_apb.sv
// ----------------------------------------------------------------------------
// cdft_apb
// Configuration registers behind an APB-style port, with length clamping.
// ----------------------------------------------------------------------------
module cdft_apb import cdft_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    localparam logic [LOG2_BITS-1:0] LOG2_MAX = LOG2_BITS'($clog2(MAX_POINTS));

    logic                 r_inv;
    logic [LOG2_BITS-1:0] r_log2;
    logic                 wr_en;
    logic [LOG2_BITS-1:0] l_eff;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv  <= 1'b0;
            r_log2 <= LOG2_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                CFG_IDX_INV:  r_inv  <= pwdata[0];
                CFG_IDX_LOG2: r_log2 <= pwdata[LOG2_BITS-1:0];
                default:      r_inv  <= r_inv;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_IDX_INV:  prdata = {{(CFG_DW-1){1'b0}}, r_inv};
            CFG_IDX_LOG2: prdata = {{(CFG_DW-LOG2_BITS){1'b0}}, r_log2};
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        if (r_log2 < LOG2_MIN) begin
            l_eff = LOG2_MIN;
        end else if (r_log2 > LOG2_MAX) begin
            l_eff = LOG2_MAX;
        end else begin
            l_eff = r_log2;
        end
    end

    assign o_cfg.inv    = r_inv;
    assign o_cfg.l_eff  = l_eff;
    assign o_cfg.len_wr = wr_en & (paddr[2] == CFG_IDX_LOG2);

endmodule

FILE: hw/rtl/cdft_seq.sv
// ----------------------------------------------------------------------------
// cdft_seq
// Frame loader and bin/term sequencer driving the shared complex MAC.
// ----------------------------------------------------------------------------
module cdft_seq import cdft_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  t_cfg                          i_cfg,
    input  logic                          i_done,
    output logic                          o_busy,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_POINTS)-1:0] o_wr_addr,
    output logic [$clog2(MAX_POINTS)-1:0] o_rd_addr,
    output t_mac_ctrl                     o_ctrl,
    output logic [TABLE_BITS-1:0]         o_phase
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;

    t_seq_state            r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [AW-1:0]         r_n, n_n;
    logic [AW-1:0]         r_k, n_k;
    logic [TABLE_BITS-1:0] r_phase, n_phase;
    logic [TABLE_BITS-1:0] r_kstep, n_kstep;

    logic [CW-1:0]         pts;
    logic [AW-1:0]         last_idx;
    logic [CW-1:0]         cnt_eff;
    logic [CW-1:0]         cnt_inc;
    logic [LOG2_BITS-1:0]  step_sh;
    logic [TABLE_BITS-1:0] step;
    logic                  accept;
    logic                  frame_full;
    logic                  term_last;
    logic                  bin_last;

    assign pts        = CW'(1) << i_cfg.l_eff;
    assign last_idx   = AW'(pts - CW'(1));
    assign step_sh    = LOG2_BITS'(TABLE_BITS) - i_cfg.l_eff;
    assign step       = TABLE_BITS'(1) << step_sh;
    assign accept     = i_start & (r_state == SEQ_IDLE);
    assign cnt_eff    = (r_cnt >= pts) ? '0 : r_cnt;
    assign cnt_inc    = cnt_eff + CW'(1);
    assign frame_full = accept & (cnt_inc == pts);
    assign term_last  = (r_n == last_idx);
    assign bin_last   = (r_k == last_idx);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (frame_full) begin
                    n_state = SEQ_CALC;
                end
            end
            SEQ_CALC: begin
                if (term_last && bin_last) begin
                    n_state = SEQ_FLUSH;
                end
            end
            SEQ_FLUSH: begin
                if (i_done) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy        = 1'b1;
        o_wr_en       = 1'b0;
        o_ctrl        = '0;
        case (r_state)
            SEQ_IDLE: begin
                o_busy  = 1'b0;
                o_wr_en = accept;
            end
            SEQ_CALC: begin
                o_ctrl.valid  = 1'b1;
                o_ctrl.first  = (r_n == '0);
                o_ctrl.last   = term_last;
                o_ctrl.last_k = bin_last;
                o_ctrl.k      = IDX_BITS'(r_k);
            end
            SEQ_FLUSH: o_busy = 1'b1;
            default:   o_busy = 1'b1;
        endcase
    end

    assign o_wr_addr = cnt_eff[AW-1:0];
    assign o_rd_addr = r_n;
    assign o_phase   = r_phase;

    // counters
    always_comb begin
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_k     = r_k;
        n_phase = r_phase;
        n_kstep = r_kstep;
        if (accept) begin
            n_cnt = frame_full ? '0 : cnt_inc;
        end
        if (i_cfg.len_wr) begin
            n_cnt = '0;
        end
        if (frame_full) begin
            n_n     = '0;
            n_k     = '0;
            n_phase = '0;
            n_kstep = '0;
        end else if (r_state == SEQ_CALC) begin
            if (term_last) begin
                n_n     = '0;
                n_k     = r_k + AW'(1);
                n_kstep = r_kstep + step;
                n_phase = '0;
            end else begin
                n_n     = r_n + AW'(1);
                n_phase = r_phase + r_kstep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_cnt   <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_phase <= '0;
            r_kstep <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_k     <= n_k;
            r_phase <= n_phase;
            r_kstep <= n_kstep;
        end
    end

endmodule

FILE: hw/rtl/cdft_mac.sv
// ----------------------------------------------------------------------------
// cdft_mac
// Shared complex multiply-accumulate pipeline with rounding and saturation.
// ----------------------------------------------------------------------------
module cdft_mac import cdft_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctrl                  i_ctrl,
    input  logic [TABLE_BITS-1:0]      i_phase,
    input  logic [2*SAMPLE_BITS-1:0]   i_rd_data,
    input  logic                       i_inv,
    input  logic [LOG2_BITS-1:0]       i_l_eff,
    output logic                       o_bin_valid,
    output logic signed [BIN_BITS-1:0] o_bin_re,
    output logic signed [BIN_BITS-1:0] o_bin_im,
    output logic [IDX_BITS-1:0]        o_bin_index,
    output logic                       o_last_bin
);

    localparam int PW    = SAMPLE_BITS + TWID_BITS;
    localparam int SW    = PW + 1;
    localparam int ACC_W = SW + $clog2(MAX_POINTS) + 1;
    localparam int QW    = ACC_W - FRAC_BITS;
    localparam int RW    = (QW > BIN_BITS) ? QW : BIN_BITS + 1;

    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(2**(FRAC_BITS-1));
    localparam logic signed [RW-1:0]    SAT_HI = RW'(2**(BIN_BITS-1) - 1);
    localparam logic signed [RW-1:0]    SAT_LO = RW'(-(2**(BIN_BITS-1)));

    // twiddle fetch, aligned with the registered sample read
    t_mac_ctrl                     r1_ctrl;
    logic signed [TWID_BITS-1:0]   r1_cos;
    logic signed [TWID_BITS-1:0]   r1_sin;
    logic [TABLE_BITS-1:0]         sin_idx;
    logic signed [SAMPLE_BITS-1:0] xr;
    logic signed [SAMPLE_BITS-1:0] xi;

    // products
    t_mac_ctrl                     r2_ctrl;
    logic signed [PW-1:0]          p_rc, p_is, p_ic, p_rs;
    logic signed [PW-1:0]          r2_rc, r2_is, r2_ic, r2_rs;

    // term sums
    t_mac_ctrl                     r3_ctrl;
    logic signed [SW-1:0]          t_re, t_im;
    logic signed [SW-1:0]          r3_re, r3_im;

    // accumulator
    logic                          r4_done;
    logic [IDX_BITS-1:0]           r4_k;
    logic                          r4_last_k;
    logic signed [ACC_W-1:0]       r4_acc_re, r4_acc_im;

    // rounding and inverse scaling
    logic signed [ACC_W-1:0]       rnd_re, rnd_im;
    logic signed [RW-1:0]          q_re, q_im;
    logic                          r5_valid;
    logic [IDX_BITS-1:0]           r5_k;
    logic                          r5_last_k;
    logic signed [RW-1:0]          r5_re, r5_im;

    // output register
    logic                          r6_valid;
    logic [IDX_BITS-1:0]           r6_k;
    logic                          r6_last_k;
    logic signed [BIN_BITS-1:0]    r6_re, r6_im;
    logic signed [BIN_BITS-1:0]    sat_re, sat_im;

    assign sin_idx = i_phase + TABLE_BITS'(SIN_OFFSET);

    always_ff @(posedge i_clk) begin
        r1_cos <= COS_TAB[i_phase];
        r1_sin <= COS_TAB[sin_idx];
    end

    assign xr = $signed(i_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign xi = $signed(i_rd_data[SAMPLE_BITS-1:0]);

    assign p_rc = xr * r1_cos;
    assign p_is = xi * r1_sin;
    assign p_ic = xi * r1_cos;
    assign p_rs = xr * r1_sin;

    always_ff @(posedge i_clk) begin
        r2_rc <= p_rc;
        r2_is <= p_is;
        r2_ic <= p_ic;
        r2_rs <= p_rs;
    end

    always_comb begin
        if (i_inv) begin
            t_re = SW'(r2_rc) - SW'(r2_is);
            t_im = SW'(r2_ic) + SW'(r2_rs);
        end else begin
            t_re = SW'(r2_rc) + SW'(r2_is);
            t_im = SW'(r2_ic) - SW'(r2_rs);
        end
    end

    always_ff @(posedge i_clk) begin
        r3_re <= t_re;
        r3_im <= t_im;
    end

    always_ff @(posedge i_clk) begin
        if (r3_ctrl.valid) begin
            if (r3_ctrl.first) begin
                r4_acc_re <= ACC_W'(r3_re);
                r4_acc_im <= ACC_W'(r3_im);
            end else begin
                r4_acc_re <= r4_acc_re + ACC_W'(r3_re);
                r4_acc_im <= r4_acc_im + ACC_W'(r3_im);
            end
        end
        r4_k      <= r3_ctrl.k;
        r4_last_k <= r3_ctrl.last_k;
    end

    assign rnd_re = r4_acc_re + HALF;
    assign rnd_im = r4_acc_im + HALF;

    always_comb begin
        q_re = RW'($signed(rnd_re[ACC_W-1:FRAC_BITS]));
        q_im = RW'($signed(rnd_im[ACC_W-1:FRAC_BITS]));
        if (i_inv) begin
            q_re = q_re >>> i_l_eff;
            q_im = q_im >>> i_l_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_re     <= q_re;
        r5_im     <= q_im;
        r5_k      <= r4_k;
        r5_last_k <= r4_last_k;
    end

    always_comb begin
        if (r5_re > SAT_HI) begin
            sat_re = BIN_BITS'(SAT_HI);
        end else if (r5_re < SAT_LO) begin
            sat_re = BIN_BITS'(SAT_LO);
        end else begin
            sat_re = r5_re[BIN_BITS-1:0];
        end
        if (r5_im > SAT_HI) begin
            sat_im = BIN_BITS'(SAT_HI);
        end else if (r5_im < SAT_LO) begin
            sat_im = BIN_BITS'(SAT_LO);
        end else begin
            sat_im = r5_im[BIN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r6_re     <= sat_re;
        r6_im     <= sat_im;
        r6_k      <= r5_k;
        r6_last_k <= r5_last_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl  <= '0;
            r2_ctrl  <= '0;
            r3_ctrl  <= '0;
            r4_done  <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r1_ctrl  <= i_ctrl;
            r2_ctrl  <= r1_ctrl;
            r3_ctrl  <= r2_ctrl;
            r4_done  <= r3_ctrl.valid & r3_ctrl.last;
            r5_valid <= r4_done;
            r6_valid <= r5_valid;
        end
    end

    assign o_bin_valid = r6_valid;
    assign o_bin_re    = r6_re;
    assign o_bin_im    = r6_im;
    assign o_bin_index = r6_k;
    assign o_last_bin  = r6_last_k;

endmodule

FILE: hw/rtl/complex_dft_idft_top.sv
// ----------------------------------------------------------------------------
// complex_dft_idft_top
// Direct complex DFT / inverse DFT over a power-of-two frame of Q1.15 samples.
//
// channel   direction  transfer              payload
// sample    in         start & !busy         i_sample_re, i_sample_im
// bin       out        o_bin_valid (1 cycle) o_bin_re, o_bin_im, o_bin_index,
//                                            o_last_bin
// config    in/out     psel&penable&pwrite   paddr, pwdata, prdata
//
// a sample is stored on each accepted start; busy stays low until the
// frame is full; the last sample of a frame of N points starts the busy
// phase: one complex multiply-accumulate per cycle through the shared
// MAC pipeline, one bin out per index k, busy low again after the last bin
// synchronous reset clears control only; the sample store needs no clearing
// results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module complex_dft_idft_top import cdft_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_im,
    output logic                          o_bin_valid,
    output logic signed [BIN_BITS-1:0]    o_bin_re,
    output logic signed [BIN_BITS-1:0]    o_bin_im,
    output logic [IDX_BITS-1:0]           o_bin_index,
    output logic                          o_last_bin,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_AW-1:0]             paddr,
    input  logic [CFG_DW-1:0]             pwdata,
    output logic [CFG_DW-1:0]             prdata,
    output logic                          pready
);

    localparam int AW = $clog2(MAX_POINTS);

    t_cfg                    cfg;
    t_mac_ctrl               ctrl;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic [2*SAMPLE_BITS-1:0] rd_data;
    logic [TABLE_BITS-1:0]   phase;
    logic                    frame_done;
    logic [IDX_BITS:0]       pts;
    logic [IDX_BITS-1:0]     last_k_idx;

    assign frame_done = o_bin_valid & o_last_bin;
    assign pts        = (IDX_BITS+1)'(1) << cfg.l_eff;
    assign last_k_idx = IDX_BITS'(pts - (IDX_BITS+1)'(1));

    cdft_apb #(
        .MAX_POINTS (MAX_POINTS)
    ) u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cdft_seq #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cfg     (cfg),
        .i_done    (frame_done),
        .o_busy    (busy),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr),
        .o_ctrl    (ctrl),
        .o_phase   (phase)
    );

    cdft_ram #(
        .WIDTH (2*SAMPLE_BITS),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_sample_re, i_sample_im}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cdft_mac #(
        .MAX_POINTS  (MAX_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_phase     (phase),
        .i_rd_data   (rd_data),
        .i_inv       (cfg.inv),
        .i_l_eff     (cfg.l_eff),
        .o_bin_valid (o_bin_valid),
        .o_bin_re    (o_bin_re),
        .o_bin_im    (o_bin_im),
        .o_bin_index (o_bin_index),
        .o_last_bin  (o_last_bin)
    );

`ifndef SYNTHESIS
    a_bin_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bin_valid |-> busy)
        else $error("bin transfer outside a busy frame");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bin_valid && o_last_bin) |=> !busy)
        else $error("busy held after the last bin");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bin_valid && o_last_bin) |-> (o_bin_index == last_k_idx))
        else $error("last bin index does not match frame length");

    a_busy_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without a sample transfer");
`endif

endmodule
